@@ rtl/assert_macros.svh @@
// assertion macros shared by the deque rtl
// needs a clock named aclk and an active-low reset named aresetn in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CDQ_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("cdq same-cycle check failed");

// next-cycle implication
`define CDQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("cdq next-cycle check failed");

`endif

@@ rtl/cdq_pkg.sv @@
// types, constants and codes for the circular buffer deque
// no dependencies
`default_nettype none

package cdq_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int WORD_W     = 32;
    localparam int KIND_W     = 2;
    localparam int STATUS_W   = 2;
    localparam int OCC_W      = 5;
    localparam int S_TDATA_W  = 32;
    localparam int M_TDATA_W  = 40;

    typedef enum logic [KIND_W-1:0] {
        KIND_PUSH_BACK  = 2'd0,
        KIND_PUSH_FRONT = 2'd1,
        KIND_POP_BACK   = 2'd2,
        KIND_POP_FRONT  = 2'd3
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        OP_HOLD,
        OP_SHIFT_IN,
        OP_SHIFT_OUT,
        OP_APPEND,
        OP_DROP
    } cell_op_t;

    typedef struct packed {
        cell_op_t                op;
        logic [DATA_WIDTH-1:0]   word;
    } cmd_t;

endpackage

`default_nettype wire

@@ rtl/cdq_cell.sv @@
// one storage cell of the deque chain: a word and its valid bit
// depends on cdq_pkg and assert_macros.svh
`default_nettype none

module cdq_cell (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire cdq_pkg::cmd_t                  cmd,
    input  wire logic [cdq_pkg::DATA_WIDTH-1:0] left_data,
    input  wire logic                           left_valid,
    input  wire logic [cdq_pkg::DATA_WIDTH-1:0] right_data,
    input  wire logic                           right_valid,
    output logic      [cdq_pkg::DATA_WIDTH-1:0] data_out,
    output logic                                valid_out,
    output logic      [cdq_pkg::DATA_WIDTH-1:0] tail_data
);
    import cdq_pkg::*;

    `include "assert_macros.svh"

    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;
    logic                  valid_reg;
    logic                  valid_next;
    logic                  is_tail;
    logic                  is_gap;

    assign is_tail = valid_reg && !right_valid;
    assign is_gap  = left_valid && !valid_reg;

    always_comb begin
        data_next  = data_reg;
        valid_next = valid_reg;
        unique case (cmd.op)
            OP_SHIFT_IN: begin
                data_next  = left_data;
                valid_next = left_valid;
            end
            OP_SHIFT_OUT: begin
                data_next  = right_data;
                valid_next = right_valid;
            end
            OP_APPEND: begin
                if (is_gap) begin
                    data_next  = cmd.word;
                    valid_next = 1'b1;
                end
            end
            OP_DROP: begin
                if (is_tail) begin
                    valid_next = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data_out  = data_reg;
    assign valid_out = valid_reg;
    assign tail_data = is_tail ? data_reg : '0;

    // occupied cells stay packed towards the front
    `CDQ_ASSERT_NOW(a_cell_packed, valid_reg, left_valid)

endmodule

`default_nettype wire

@@ rtl/circular_buffer_deque.sv @@
// top level of the double-ended queue: control, cell chain, result register
// depends on cdq_pkg, cdq_cell and assert_macros.svh
//
//  channel  | dir | tdata (low bit up)              | tuser
//  s_       | in  | push_value[31:0]                | kind[1:0]
//  m_       | out | pop_value[31:0], occupancy[4:0] | status[1:0]
//
//  one transaction per cycle while the output is not stalled; a result appears the cycle after its operation
//  the chain of DEPTH cells shifts in one step, so pointers never need updating
//  a new operation is taken while the result register is empty or being emptied
//  reset (aresetn low, synchronous) empties the queue; no clearing pass
`default_nettype none

module circular_buffer_deque (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [cdq_pkg::S_TDATA_W-1:0] s_tdata,  // push_value[31:0]
    input  wire logic [cdq_pkg::KIND_W-1:0]    s_tuser,  // kind[1:0]
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic      [cdq_pkg::M_TDATA_W-1:0] m_tdata,  // pop_value[31:0], occupancy[36:32]
    output logic      [cdq_pkg::STATUS_W-1:0]  m_tuser   // status[1:0]
);
    import cdq_pkg::*;

    `include "assert_macros.svh"

    logic                  accept;
    kind_t                 kind;
    cmd_t                  cmd;
    status_t               status;
    logic [WORD_W-1:0]     pop_value;
    logic [DATA_WIDTH-1:0] back_word;
    logic                  full;
    logic                  empty;
    logic                  is_push;
    logic                  is_pop;
    logic                  full_push;
    logic                  res_full;

    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic                  m_tvalid_reg;
    logic                  m_tvalid_next;
    logic [WORD_W-1:0]     pop_value_reg;
    logic [OCC_W-1:0]      occ_reg;
    status_t               status_reg;

    logic [DATA_WIDTH-1:0] cell_data  [DEPTH];
    logic [DEPTH-1:0]      cell_valid;
    logic [DATA_WIDTH-1:0] cell_tail  [DEPTH];
    logic [DATA_WIDTH-1:0] left_data  [DEPTH];
    logic [DEPTH-1:0]      left_valid;
    logic [DATA_WIDTH-1:0] right_data [DEPTH];
    logic [DEPTH-1:0]      right_valid;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign kind     = kind_t'(s_tuser);
    assign full     = cell_valid[DEPTH-1];
    assign empty    = !cell_valid[0];

    assign is_push   = (kind == KIND_PUSH_BACK) || (kind == KIND_PUSH_FRONT);
    assign is_pop    = !is_push;
    assign full_push = accept && full && is_push;
    assign res_full  = m_tvalid_reg && (status_reg == ST_FULL);

    // back word: only the tail cell drives its tap
    always_comb begin
        back_word = '0;
        for (int i = 0; i < DEPTH; i++) begin
            back_word = back_word | cell_tail[i];
        end
    end

    always_comb begin
        cmd.op     = OP_HOLD;
        cmd.word   = DATA_WIDTH'($signed(s_tdata[WORD_W-1:0]));
        status     = ST_OK;
        pop_value  = '1;
        count_next = count_reg;
        if (accept) begin
            unique case (kind)
                KIND_PUSH_BACK, KIND_PUSH_FRONT: begin
                    if (full) begin
                        status = ST_FULL;
                    end else begin
                        cmd.op     = (kind == KIND_PUSH_BACK) ? OP_APPEND : OP_SHIFT_IN;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                KIND_POP_BACK: begin
                    if (empty) begin
                        status = ST_EMPTY;
                    end else begin
                        cmd.op     = OP_DROP;
                        pop_value  = WORD_W'($signed(back_word));
                        count_next = count_reg - CNT_W'(1);
                    end
                end
                KIND_POP_FRONT: begin
                    if (empty) begin
                        status = ST_EMPTY;
                    end else begin
                        cmd.op     = OP_SHIFT_OUT;
                        pop_value  = WORD_W'($signed(cell_data[0]));
                        count_next = count_reg - CNT_W'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            if (g == 0) begin : g_first
                assign left_data[g]  = cmd.word;
                assign left_valid[g] = 1'b1;
            end else begin : g_mid_l
                assign left_data[g]  = cell_data[g-1];
                assign left_valid[g] = cell_valid[g-1];
            end
            if (g == DEPTH - 1) begin : g_last
                assign right_data[g]  = '0;
                assign right_valid[g] = 1'b0;
            end else begin : g_mid_r
                assign right_data[g]  = cell_data[g+1];
                assign right_valid[g] = cell_valid[g+1];
            end

            cdq_cell u_cell (
                .aclk        (aclk),
                .aresetn     (aresetn),
                .cmd         (cmd),
                .left_data   (left_data[g]),
                .left_valid  (left_valid[g]),
                .right_data  (right_data[g]),
                .right_valid (right_valid[g]),
                .data_out    (cell_data[g]),
                .valid_out   (cell_valid[g]),
                .tail_data   (cell_tail[g])
            );
        end
    endgenerate

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (accept) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            pop_value_reg <= pop_value;
            status_reg    <= status;
            occ_reg       <= OCC_W'(count_next);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_TDATA_W'({occ_reg, pop_value_reg});
    assign m_tuser  = status_reg;

    // occupancy counter tracks the valid bits of the chain
    `CDQ_ASSERT_NOW(a_count_matches, 1'b1, $countones(cell_valid) == 32'(count_reg))
    // a push on a full queue changes nothing
    `CDQ_ASSERT_NEXT(a_full_hold, full_push, count_reg == CNT_W'(DEPTH) && res_full)
    // a pop on a non-empty queue reports success
    `CDQ_ASSERT_NEXT(a_pop_ok, accept && !empty && is_pop, m_tvalid_reg && status_reg == ST_OK)

endmodule

`default_nettype wire

@@ sim/cdq_checker.sv @@
// transaction checker for the circular buffer deque: watches both stream channels,
// keeps its own copy of the ring and compares every result with the predicted one
// depends on cdq_pkg
module cdq_checker (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    input  wire logic                          s_tready,
    input  wire logic [cdq_pkg::S_TDATA_W-1:0] s_tdata,   // push_value[31:0]
    input  wire logic [cdq_pkg::KIND_W-1:0]    s_tuser,   // kind[1:0]
    input  wire logic                          m_tvalid,
    input  wire logic                          m_tready,
    input  wire logic [cdq_pkg::M_TDATA_W-1:0] m_tdata,   // pop_value[31:0], occupancy[36:32]
    input  wire logic [cdq_pkg::STATUS_W-1:0]  m_tuser,   // status[1:0]
    output int                                 mismatches,
    output int                                 outstanding
);
    import cdq_pkg::*;

    typedef struct {
        logic [WORD_W-1:0] pop_value;
        status_t           status;
        logic [OCC_W-1:0]  occupancy;
    } deque_result_t;

    logic signed [DATA_WIDTH-1:0] ring_words [DEPTH];
    int                           front_pos;
    int                           back_pos;
    int                           word_count;
    deque_result_t                awaited_results [$];

    initial begin
        mismatches  = 0;
        outstanding = 0;
    end

    function automatic int wrap_up(input int pos);
        return (pos + 1 >= DEPTH) ? 0 : pos + 1;
    endfunction

    function automatic int wrap_down(input int pos);
        return (pos == 0) ? DEPTH - 1 : pos - 1;
    endfunction

    task automatic apply_deque_op(input kind_t op, input logic [WORD_W-1:0] word,
                                  output deque_result_t res);
        logic signed [WORD_W-1:0] widened;
        res.pop_value = '1;
        res.status    = ST_OK;
        case (op)
            KIND_PUSH_BACK, KIND_PUSH_FRONT: begin
                if (word_count >= DEPTH) begin
                    res.status = ST_FULL;
                end else if (op == KIND_PUSH_BACK) begin
                    back_pos = wrap_up(back_pos);
                    ring_words[back_pos] = word[DATA_WIDTH-1:0];
                    word_count++;
                end else begin
                    front_pos = wrap_down(front_pos);
                    ring_words[front_pos] = word[DATA_WIDTH-1:0];
                    word_count++;
                end
            end
            default: begin
                if (word_count == 0) begin
                    res.status = ST_EMPTY;
                end else if (op == KIND_POP_BACK) begin
                    widened = ring_words[back_pos];
                    res.pop_value = widened;
                    back_pos = wrap_down(back_pos);
                    word_count--;
                end else begin
                    widened = ring_words[front_pos];
                    res.pop_value = widened;
                    front_pos = wrap_up(front_pos);
                    word_count--;
                end
            end
        endcase
        res.occupancy = OCC_W'(word_count);
    endtask

    always @(posedge aclk) begin : watch
        deque_result_t    fresh;
        deque_result_t    oldest;
        logic [WORD_W-1:0] got_value;
        logic [OCC_W-1:0]  got_occ;
        got_value = m_tdata[WORD_W-1:0];
        got_occ   = m_tdata[WORD_W +: OCC_W];
        if (!aresetn) begin
            front_pos  = 0;
            back_pos   = DEPTH - 1;
            word_count = 0;
            awaited_results.delete();
        end else begin
            // input first so a result given in the same cycle as its operation would still find its entry
            if (s_tvalid && s_tready) begin
                apply_deque_op(kind_t'(s_tuser), s_tdata[WORD_W-1:0], fresh);
                awaited_results.insert(awaited_results.size(), fresh);
            end
            if (m_tvalid && m_tready) begin
                if (awaited_results.size() == 0) begin
                    if (mismatches < 10)
                        $display("cdq_checker: unexpected result value=%h status=%0d occ=%0d",
                                 got_value, m_tuser, got_occ);
                    mismatches++;
                end else begin
                    oldest = awaited_results[0];
                    awaited_results.delete(0);
                    if (got_value !== oldest.pop_value || m_tuser !== oldest.status ||
                        got_occ !== oldest.occupancy) begin
                        if (mismatches < 10)
                            $display({"cdq_checker: mismatch expected value=%h status=%0d ",
                                      "occ=%0d, got value=%h status=%0d occ=%0d"},
                                     oldest.pop_value, oldest.status, oldest.occupancy,
                                     got_value, m_tuser, got_occ);
                        mismatches++;
                    end
                end
            end
        end
        outstanding = awaited_results.size();
    end

endmodule

@@ sim/tb.sv @@
// testbench top for the circular buffer deque: clock, reset, stimulus and verdict
// depends on cdq_pkg, circular_buffer_deque and cdq_checker
module tb;
    import cdq_pkg::*;

    localparam int RANDOM_OPS   = 1150;
    localparam int STALL_CYCLES = 80;
    localparam int DRAIN_CYCLES = 10;
    localparam int QUIET_LIMIT  = 1000;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic [S_TDATA_W-1:0]  s_tdata  = '0;
    logic [KIND_W-1:0]     s_tuser  = '0;
    logic                  m_tready = 1'b0;
    logic                  s_tready;
    logic                  m_tvalid;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [STATUS_W-1:0]   m_tuser;

    int mismatches;
    int outstanding;
    int send_idle_pct = 33;
    int recv_idle_pct = 46;
    int phase_no      = 0;
    int quiet_cycles  = 0;

    always #6 aclk = ~aclk;

    circular_buffer_deque i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    cdq_checker i_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // receiver side, with one long hold-off when the last phase starts
    initial begin : rx_side
        int  hold_left;
        bit  held;
        hold_left = 0;
        held      = 1'b0;
        forever begin
            @(posedge aclk);
            if (phase_no == 2 && !held) begin
                held      = 1'b1;
                hold_left = STALL_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    task automatic offer_op(input kind_t op, input logic [WORD_W-1:0] word);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= word;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(9))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return '1;
            3:       return '0;
            default: return $urandom;
        endcase
    endfunction

    function automatic kind_t pick_op(input int push_pct);
        if ($urandom_range(99) < push_pct)
            return $urandom_range(1) ? KIND_PUSH_FRONT : KIND_PUSH_BACK;
        return $urandom_range(1) ? KIND_POP_FRONT : KIND_POP_BACK;
    endfunction

    // runs of push-heavy, pop-heavy and balanced traffic so the ring fills and drains
    task automatic run_random(input int n_ops);
        int push_pct;
        int run_left;
        push_pct = 50;
        run_left = 0;
        for (int i = 0; i < n_ops; i++) begin
            if (run_left == 0) begin
                run_left = $urandom_range(60, 20);
                case ($urandom_range(2))
                    0:       push_pct = 85;
                    1:       push_pct = 15;
                    default: push_pct = 50;
                endcase
            end
            run_left--;
            offer_op(pick_op(push_pct), pick_word());
        end
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty pops, then both ends with extreme words
        offer_op(KIND_POP_BACK, '1);
        offer_op(KIND_POP_FRONT, '0);
        offer_op(KIND_PUSH_BACK, 32'h7FFF_FFFF);
        offer_op(KIND_PUSH_FRONT, 32'h8000_0000);
        offer_op(KIND_POP_BACK, '0);
        offer_op(KIND_POP_FRONT, '1);
        // fill to the brim from both ends, wrapping the indices
        for (int i = 0; i < DEPTH; i++) begin
            case (i % 4)
                0:       offer_op(i % 2 ? KIND_PUSH_FRONT : KIND_PUSH_BACK, '0);
                1:       offer_op(i % 2 ? KIND_PUSH_FRONT : KIND_PUSH_BACK, '1);
                2:       offer_op(i % 2 ? KIND_PUSH_FRONT : KIND_PUSH_BACK, 32'h7FFF_FFFF);
                default: offer_op(i % 2 ? KIND_PUSH_FRONT : KIND_PUSH_BACK, 32'h8000_0000);
            endcase
        end
        offer_op(KIND_PUSH_BACK, $urandom);
        offer_op(KIND_PUSH_FRONT, $urandom);

        run_random(RANDOM_OPS / 3);
        send_idle_pct = 46;
        recv_idle_pct = 33;
        phase_no      = 1;
        run_random(RANDOM_OPS / 3);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        phase_no      = 2;
        run_random(RANDOM_OPS - 2 * (RANDOM_OPS / 3));
        s_tvalid <= 1'b0;

        while (outstanding != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
